### rtl/shm_pkg.sv
// ============================================================================
// shm_pkg
// Shared types, constants and round functions of the SHA-256 message hasher.
// ============================================================================
package shm_pkg;

   // eight 32-bit words of chain or working state, word 0 in slice 0
   typedef logic [7:0][31:0] hash_type;

   // sixteen-word message schedule window
   typedef logic [15:0][31:0] sched_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   // message-end padding progress
   typedef enum logic [2:0] {
      PAD_NONE,
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN,
      PAD_DONE
   } pad_type;

   // controls for the schedule window
   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       step;
      logic [5:0] round_idx;
   } sched_ctrl_type;

   // controls for the round unit
   typedef struct packed {
      logic       load;
      logic       round;
      logic       finalize;
      logic       reinit;
      logic [5:0] round_idx;
   } round_ctrl_type;

   localparam int unsigned BlockBytes = 64;
   localparam logic [5:0]  PadLenStart = 6'd56;   // 448 bits into the block
   localparam logic [7:0]  PadMarkByte = 8'h80;

   localparam hash_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
      rotr = (x >> s) | (x << (32 - s));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

### rtl/shm_req_if.sv
// ============================================================================
// shm_req_if
// Message byte channel: valid/ready handshake with one byte word payload.
// ============================================================================
interface shm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       message_end;

   modport source (output valid, output data_byte, output byte_valid,
                   output message_end, input ready);
   modport sink   (input valid, input data_byte, input byte_valid,
                   input message_end, output ready);
endinterface

### rtl/shm_rsp_if.sv
// ============================================================================
// shm_rsp_if
// Digest channel: valid/ready handshake carrying one digest word per transfer.
// ============================================================================
interface shm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

### rtl/shm_schedule.sv
// ============================================================================
// shm_schedule
// Sixteen-word message window: byte loading and rolling schedule expansion.
// ============================================================================
module shm_schedule
   import shm_pkg::*;
(
   input  logic           clock,
   input  sched_ctrl_type ctrl,
   output logic [31:0]    sched_word
);

   sched_type   w_ff;
   sched_type   w_in;
   logic [31:0] expand_word;

   // next schedule word; the window holds W[t-16] .. W[t-1] once t reaches 16
   always_comb begin
      expand_word = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
      sched_word  = (ctrl.round_idx[5:4] != 2'd0) ? expand_word : w_ff[0];
   end

   // byte shift on load, word shift on each round
   always_comb begin
      w_in = w_ff;
      if (ctrl.push) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
         end
         w_in[15] = {w_ff[15][23:0], ctrl.push_byte};
      end else if (ctrl.step) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = sched_word;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

endmodule

### rtl/shm_round_unit.sv
// ============================================================================
// shm_round_unit
// Shared compression round and chain value; one round per enabled cycle.
// ============================================================================
module shm_round_unit
   import shm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  logic [31:0]    sched_word,
   output hash_type       chain
);

   hash_type    chain_ff;
   hash_type    chain_in;
   hash_type    work_ff;
   hash_type    work_in;
   logic [31:0] tmp1;
   logic [31:0] tmp2;
   logic [31:0] choose;
   logic [31:0] major;

   // round datapath
   always_comb begin
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
               (work_ff[1] & work_ff[2]);
      tmp1   = work_ff[7] + big_sigma1(work_ff[4]) + choose +
               ROUND_K[ctrl.round_idx] + sched_word;
      tmp2   = big_sigma0(work_ff[0]) + major;
   end

   // working variables
   always_comb begin
      work_in = work_ff;
      if (ctrl.load) begin
         work_in = chain_ff;
      end else if (ctrl.round) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + tmp1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = tmp1 + tmp2;
      end
   end

   // chain value: add in after each block, back to initial after digest
   always_comb begin
      chain_in = chain_ff;
      if (ctrl.reinit) begin
         chain_in = INIT_HASH;
      end else if (ctrl.finalize) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_HASH;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign chain = chain_ff;

endmodule

### rtl/sha256_message_hasher_top.sv
// ============================================================================
// sha256_message_hasher_top
// Streaming SHA-256: byte input, padding, compression and digest output.
// ============================================================================
// Usage:
//   req_ch carries one item per handshake: a message byte (when byte_valid is
//   set) and a message_end flag. Bytes fill a 64-byte block most significant
//   byte first; each full block runs 64 rounds on one shared round unit, one
//   round per cycle, then adds into the chain value. ready is high only while
//   the controller is idle, so a block-completing byte holds off input until
//   the rounds and the chain update are done. On message_end the padding bytes
//   go into the window one per cycle while no block is being compressed (the
//   0x80 marker, zeros to byte 56, eight length bytes), with one or two
//   compressions, then rsp_ch gives the eight digest words, word 0
//   first, last_word set on word 7. Digest words are held until rsp_ch.ready;
//   no new input is taken until word 7 is taken, after which the chain value
//   returns to the initial hash. Synchronous reset gives the initial hash,
//   an empty block and a zero bit count; no clearing pass is needed.
// ============================================================================
module sha256_message_hasher_top
   import shm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   shm_req_if.sink   req_ch,
   shm_rsp_if.source rsp_ch
);

   state_type      state_ff;
   state_type      state_in;
   pad_type        pad_ff;
   pad_type        pad_in;
   logic [5:0]     bytes_ff;
   logic [5:0]     bytes_in;
   logic [63:0]    bit_count_ff;
   logic [63:0]    bit_count_in;
   logic [5:0]     round_ff;
   logic [5:0]     round_in;
   logic [2:0]     len_idx_ff;
   logic [2:0]     len_idx_in;
   logic [2:0]     word_idx_ff;
   logic [2:0]     word_idx_in;

   logic           req_fire;
   logic           rsp_fire;
   logic           last_out;
   logic           push;
   logic [7:0]     push_byte;
   logic           block_full;
   sched_ctrl_type sched_ctrl;
   round_ctrl_type round_ctrl;
   logic [31:0]    sched_word;
   hash_type       chain;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign last_out = rsp_fire && (word_idx_ff == 3'd7);

   // byte source for the window: input word or padding
   always_comb begin
      push      = 1'b0;
      push_byte = 8'h00;
      unique case (state_ff)
         ST_IDLE: begin
            push      = req_fire && req_ch.byte_valid;
            push_byte = req_ch.data_byte;
         end
         ST_PAD: begin
            unique case (pad_ff)
               PAD_MARK: begin
                  push      = 1'b1;
                  push_byte = PadMarkByte;
               end
               PAD_ZERO: begin
                  push = (bytes_ff != PadLenStart);
               end
               PAD_LEN: begin
                  push      = 1'b1;
                  push_byte = bit_count_ff[{len_idx_ff, 3'b000} +: 8];
               end
               default: begin
                  push = 1'b0;
               end
            endcase
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign block_full = push && (bytes_ff == 6'(BlockBytes - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (block_full) begin
                  state_in = ST_ROUND;
               end else if (req_ch.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (block_full) begin
               state_in = ST_ROUND;
            end else if (pad_ff == PAD_DONE) begin
               state_in = ST_OUT;
            end
         end
         ST_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (pad_ff == PAD_NONE) begin
               state_in = ST_IDLE;
            end else if (pad_ff == PAD_DONE) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (last_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // counters and padding progress
   always_comb begin
      pad_in       = pad_ff;
      bytes_in     = push ? bytes_ff + 6'd1 : bytes_ff;
      bit_count_in = bit_count_ff;
      round_in     = (state_ff == ST_ROUND) ? round_ff + 6'd1 : round_ff;
      len_idx_in   = len_idx_ff;
      word_idx_in  = rsp_fire ? word_idx_ff + 3'd1 : word_idx_ff;
      if (state_ff == ST_IDLE && req_fire) begin
         if (req_ch.byte_valid) begin
            bit_count_in = bit_count_ff + 64'd8;
         end
         if (req_ch.message_end) begin
            pad_in = PAD_MARK;
         end
      end
      if (state_ff == ST_PAD) begin
         unique case (pad_ff)
            PAD_MARK: begin
               pad_in = PAD_ZERO;
            end
            PAD_ZERO: begin
               if (bytes_ff == PadLenStart) begin
                  pad_in = PAD_LEN;
               end
            end
            PAD_LEN: begin
               len_idx_in = len_idx_ff - 3'd1;
               if (len_idx_ff == 3'd0) begin
                  pad_in = PAD_DONE;
               end
            end
            default: begin
               pad_in = pad_ff;
            end
         endcase
      end
      if (last_out) begin
         pad_in       = PAD_NONE;
         bit_count_in = 64'd0;
      end
   end

   // unit controls
   always_comb begin
      sched_ctrl.push      = push;
      sched_ctrl.push_byte = push_byte;
      sched_ctrl.step      = (state_ff == ST_ROUND);
      sched_ctrl.round_idx = round_ff;
      round_ctrl.load      = block_full;
      round_ctrl.round     = (state_ff == ST_ROUND);
      round_ctrl.finalize  = (state_ff == ST_FINAL);
      round_ctrl.reinit    = last_out;
      round_ctrl.round_idx = round_ff;
   end

   // handshake and digest outputs
   always_comb begin
      req_ch.ready       = (state_ff == ST_IDLE);
      rsp_ch.valid       = (state_ff == ST_OUT);
      rsp_ch.digest_word = chain[word_idx_ff];
      rsp_ch.word_index  = word_idx_ff;
      rsp_ch.last_word   = (word_idx_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_ff       <= PAD_NONE;
         bytes_ff     <= 6'd0;
         bit_count_ff <= 64'd0;
         round_ff     <= 6'd0;
         len_idx_ff   <= 3'd7;
         word_idx_ff  <= 3'd0;
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         bytes_ff     <= bytes_in;
         bit_count_ff <= bit_count_in;
         round_ff     <= round_in;
         len_idx_ff   <= len_idx_in;
         word_idx_ff  <= word_idx_in;
      end
   end

   shm_schedule u_schedule (
      .clock      (clock),
      .ctrl       (sched_ctrl),
      .sched_word (sched_word)
   );

   shm_round_unit u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (round_ctrl),
      .sched_word (sched_word),
      .chain      (chain)
   );

`ifndef NO_ASSERTIONS
   // the last round always hands over to the chain update
   a_round_to_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'd63) |=> (state_ff == ST_FINAL))
      else $error("round 63 not followed by chain update");

   // the length field starts exactly at byte 56 of the block
   a_len_position: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && pad_ff == PAD_LEN && len_idx_ff == 3'd7)
      |-> (bytes_ff == PadLenStart))
      else $error("length field misplaced in final block");

   // digest only after a completed padding with an empty block
   a_out_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (bytes_ff == 6'd0 && pad_ff == PAD_DONE))
      else $error("digest output with partial block or padding pending");

   // after the last digest word the block is ready for a new message
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      last_out |=> (req_ch.ready && bit_count_ff == 64'd0))
      else $error("not ready for a new message after digest");
`endif

endmodule

### verif/sha256_digest_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// sha256_digest_checker
// Watches the byte and digest channels of the SHA-256 message hasher. Every
// accepted byte word feeds a bit-accurate SHA-256 predictor; a message end
// queues the eight digest words it must produce. Each accepted digest word
// is compared field by field with the oldest queued word.
// ============================================================================
module sha256_digest_checker (
   input  logic clock,
   input  logic reset,
   shm_req_if   req_mon,
   shm_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   words_due
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   localparam logic [7:0] MARK_BYTE  = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;

   localparam logic [31:0] IV_WORDS [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RC [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // predictor state
   logic [31:0]      chain_val [8];
   logic [31:0]      block_buf [16];
   logic [5:0]       block_fill;
   logic [63:0]      msg_bits;
   digest_entry_type digest_due_q [$];

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // 64 rounds over the current block, added into the chain value
   task automatic compress_block;
      logic [31:0] v [8];
      logic [31:0] win [16];
      logic [31:0] wt, t1, t2, w2, w15;
      v   = chain_val;
      win = block_buf;
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wt = win[r];
         end else begin
            w2  = win[(r - 2) % 16];
            w15 = win[(r - 15) % 16];
            wt  = (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10)) + win[(r - 7) % 16]
                + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + win[r % 16];
            win[r % 16] = wt;
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RC[r] + wt;
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain_val[i] = chain_val[i] + v[i];
   endtask

   // big-endian byte into the block, compress when full
   task automatic absorb_byte(input logic [7:0] b);
      block_buf[block_fill[5:2]] = {block_buf[block_fill[5:2]][23:0], b};
      block_fill = block_fill + 6'd1;
      if (block_fill == 6'd0)
         compress_block();
   endtask

   // one accepted byte word: absorb, and on message end pad and queue digest
   task automatic predict_digest(input logic [7:0] b, input logic bv, input logic me);
      logic [63:0]      len;
      digest_entry_type e;
      if (bv) begin
         absorb_byte(b);
         msg_bits = msg_bits + 64'd8;
      end
      if (me) begin
         len = msg_bits;
         absorb_byte(MARK_BYTE);
         while (block_fill != LEN_OFFSET)
            absorb_byte(8'h00);
         for (int k = 7; k >= 0; k--)
            absorb_byte(len[8*k +: 8]);
         for (int k = 0; k < 8; k++) begin
            e.word  = chain_val[k];
            e.index = 3'(k);
            e.last  = (k == 7);
            digest_due_q = {digest_due_q, e};
         end
         chain_val  = IV_WORDS;
         block_fill = '0;
         msg_bits   = '0;
      end
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      digest_entry_type got;
      digest_entry_type want;
      if (reset) begin
         chain_val      = IV_WORDS;
         block_fill     = '0;
         msg_bits       = '0;
         mismatch_count = 0;
         digest_due_q.delete();
         for (int i = 0; i < 16; i++)
            block_buf[i] = '0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_digest(req_mon.data_byte, req_mon.byte_valid, req_mon.message_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word};
            if (digest_due_q.size() == 0) begin
               $display("%0t: unexpected digest word: expected none, actual %h/%0d/%0b",
                        $time, got.word, got.index, got.last);
               mismatch_count++;
            end else begin
               want = digest_due_q.pop_front();
               if (got !== want) begin
                  $display("%0t: digest mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
                           $time, want.word, want.index, want.last,
                           got.word, got.index, got.last);
                  mismatch_count++;
               end
            end
         end
      end
      words_due <= digest_due_q.size();
   end

endmodule

### verif/sha256_message_hasher_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// sha256_message_hasher_top_tb
// Drives byte-stream messages into the SHA-256 message hasher: a few
// directed messages (empty, idle words, short text, end without a byte),
// then random messages, mostly short, some at the one- and two-block
// padding boundaries, under three idling profiles and one long digest stall.
// The checker beside the block predicts and compares every digest word.
// ============================================================================
module sha256_message_hasher_top_tb;

   localparam int HOLD_CYCLES  = 600;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 150;
   localparam int MODE_WORDS   = 30;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_requests = 0;
   int   words_sent    = 0;
   int   mismatch_count;
   int   words_due;

   shm_req_if req_ch ();
   shm_rsp_if rsp_ch ();

   sha256_message_hasher_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sha256_digest_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   always #6 clock = ~clock;

   // offer one byte word, with random idle cycles ahead of it
   task automatic send_word(input logic [7:0] b, input logic bv, input logic me);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.byte_valid  <= bv;
      req_ch.message_end <= me;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      words_sent++;
   endtask

   // random message, sometimes with idle words inside and an end without a byte
   task automatic send_message(input int len);
      logic end_on_byte;
      end_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 5)
            send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte)
         send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   // mostly short messages, some right at the padding boundaries
   function automatic int pick_length();
      int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int r;
      r = $urandom_range(9);
      if (r < 6)
         return $urandom_range(8);
      else if (r < 8)
         return edges[$urandom_range(7)];
      return $urandom_range(40, 9);
   endfunction

   // digest receiver: random stalls, plus long hold-offs on request
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no word accepted on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int mode_words;
      int mode_msgs;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= '0;
      req_ch.byte_valid  <= 1'b0;
      req_ch.message_end <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 65;

      // empty message, then an idle word
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b0);
      // "abc", ending on the last byte
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      // extreme bytes, idle word inside, end word without a byte
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h5a, 1'b0, 1'b0);
      send_word(8'hff, 1'b0, 1'b1);
      // two single byte messages
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);

      // random messages under each idling profile
      for (int mode = 0; mode < 3; mode++) begin
         if (mode == 1) begin
            send_idle_pct = 65;
            recv_idle_pct = 7;
         end else if (mode == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // long digest stall while the next message keeps coming
            hold_requests++;
            send_message(24);
         end
         mode_words = words_sent;
         mode_msgs  = 0;
         while ((words_sent - mode_words) < MODE_WORDS || mode_msgs < 3) begin
            send_message(pick_length());
            mode_msgs++;
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/shm_pkg.sv
rtl/shm_req_if.sv
rtl/shm_rsp_if.sv
rtl/shm_schedule.sv
rtl/shm_round_unit.sv
rtl/sha256_message_hasher_top.sv
verif/sha256_digest_checker.sv
verif/sha256_message_hasher_top_tb.sv
